@@ sv/pbc_pkg.sv @@
package pbc_pkg;

    localparam int HASH_BITS      = 12;
    localparam int HASH_SHIFT     = 5;
    localparam int TABLE_DEPTH    = 2 ** HASH_BITS;
    localparam int BUF_ADDR_BITS  = 16;
    localparam int LIMIT_BITS     = BUF_ADDR_BITS + 1;
    localparam int BYTE_BITS      = 8;
    localparam int FLAGS_PER_BYTE = 8;
    localparam int FLAG_CNT_BITS  = 3;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = LIMIT_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_OFFSET = 1'd1;

    localparam logic [LIMIT_BITS-1:0] ADDR_SPACE = LIMIT_BITS'(1) << BUF_ADDR_BITS;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    localparam int S_TDATA_BITS   = 8;
    localparam int M_TDATA_BITS   = 32;

    typedef struct packed {
        logic                     write_enable;
        logic [BUF_ADDR_BITS-1:0] write_addr;
        logic [BYTE_BITS-1:0]     write_data;
        logic                     is_flag_byte;
        logic                     overflow;
        logic                     last;
    } result_t;

    // Up to two results enter the queue together; the second only with the first.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

@@ sv/pbc_ram.sv @@
module pbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pbc_result_fifo.sv @@
module pbc_result_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pbc_pkg::push_t                       push,
    input  logic                                 pop,
    output pbc_pkg::result_t                     head,
    output logic [pbc_pkg::FIFO_CNT_BITS-1:0]    fill_count
);
    import pbc_pkg::*;

    result_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic [FIFO_CNT_BITS-1:0] count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_second;
    logic [FIFO_CNT_BITS-1:0] push_num;

    always_comb
    begin
        wr_ptr_second = wr_ptr_reg + FIFO_PTR_BITS'(1);
        push_num      = FIFO_CNT_BITS'(push.valid0) + FIFO_CNT_BITS'(push.valid1);
        wr_ptr_next   = wr_ptr_reg + push_num[FIFO_PTR_BITS-1:0];
        rd_ptr_next   = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next    = count_reg + push_num - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            entry_reg[wr_ptr_second] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign fill_count = count_reg;

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue holds more words than its depth");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0)
        else $error("second result pushed without the first");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue popped while empty");
`endif

endmodule

@@ sv/predictor_byte_compressor_core.sv @@
// An accepted byte passes the input register and then the result queue on its way to m_axis.
// Throughput: one byte per cycle while the output side drains; since a byte can give two
// words and m_axis moves one word per cycle, the output port sets the sustained figure.
// Reset (rst_n, asynchronous, active low) initialises all control state and then runs a
// pass that zeroes every guess table entry; s_axis_tready stays low during that pass.
module predictor_byte_compressor_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port (no read-back).
    input  logic                                 cfg_we,
    input  logic [pbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pbc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pbc_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic                                 s_axis_tlast,  // block_end
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] write_enable, [16:1] write_addr, [24:17] write_data, [25] overflow, rest zero
    output logic [pbc_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,
    output logic                                 m_axis_tuser,  // is_flag_byte
    output logic                                 m_axis_tlast   // last
);
    import pbc_pkg::*;

    // ------------------------------------------------------------------
    // Table clear after reset. The counter walks every table entry once;
    // its top bit marks the end of the pass.
    // ------------------------------------------------------------------
    logic [HASH_BITS:0]            clr_cnt_reg;
    logic [HASH_BITS:0]            clr_cnt_next;
    logic                          clr_done;

    // Configuration and coding state.
    logic [LIMIT_BITS-1:0]         limit_reg;
    logic [LIMIT_BITS-1:0]         limit_next;
    logic [HASH_BITS-1:0]          hash_reg;
    logic [HASH_BITS-1:0]          hash_next;
    logic [BYTE_BITS-1:0]          flag_bits_reg;
    logic [BYTE_BITS-1:0]          flag_bits_next;
    logic [FLAG_CNT_BITS-1:0]      flag_cnt_reg;
    logic [FLAG_CNT_BITS-1:0]      flag_cnt_next;
    logic [BUF_ADDR_BITS-1:0]      flag_slot_reg;
    logic [BUF_ADDR_BITS-1:0]      flag_slot_next;
    logic [LIMIT_BITS-1:0]         write_pos_reg;
    logic [LIMIT_BITS-1:0]         write_pos_next;
    logic                          ovf_reg;
    logic                          ovf_next;

    // Input register: the accepted byte waits here while the table read completes.
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [BYTE_BITS-1:0]          s1_byte_reg;
    // Forwarding: the table write of the previous byte lands in the same cycle as this
    // byte's read, so a matching index takes the written value instead of the RAM data.
    logic                          fwd_reg;
    logic                          fwd_next;
    logic [BYTE_BITS-1:0]          fwd_data_reg;

    logic                          accept;
    logic                          s1_fire;
    logic                          commit;
    logic [BYTE_BITS-1:0]          ram_rdata;
    logic [BYTE_BITS-1:0]          guess;
    logic                          hit;
    logic                          completes;
    logic [1:0]                    need;
    logic [LIMIT_BITS-1:0]         limit_eff;
    logic [LIMIT_BITS:0]           need_end;
    logic                          drop;
    logic [BYTE_BITS-1:0]          flag_shift;
    logic [HASH_BITS-1:0]          hash_upd;
    logic [LIMIT_BITS-1:0]         pos_after_lit;
    logic                          tbl_we;
    logic [HASH_BITS-1:0]          tbl_waddr;
    logic [BYTE_BITS-1:0]          tbl_wdata;

    push_t                         push;
    result_t                       lit_res;
    result_t                       flag_res;
    result_t                       ovf_res;
    result_t                       head;
    logic [FIFO_CNT_BITS-1:0]      fill_count;
    logic                          pop;

    assign clr_done = clr_cnt_reg[HASH_BITS];

    // ------------------------------------------------------------------
    // Coding decision for the byte held in the input register.
    // ------------------------------------------------------------------
    always_comb
    begin
        guess      = fwd_reg ? fwd_data_reg : ram_rdata;
        hit        = (guess == s1_byte_reg);
        completes  = (flag_cnt_reg == FLAG_CNT_BITS'(FLAGS_PER_BYTE - 1));
        need       = 2'(!hit) + 2'(completes);
        // Limits above the address space are clamped to it.
        limit_eff  = (limit_reg > ADDR_SPACE) ? ADDR_SPACE : limit_reg;
        need_end   = {1'b0, write_pos_reg} + (LIMIT_BITS + 1)'(need);
        drop       = ovf_reg || (need_end > {1'b0, limit_eff});
        flag_shift = {flag_bits_reg[BYTE_BITS-2:0], hit};
        hash_upd   = {hash_reg[HASH_BITS-HASH_SHIFT-1:0], HASH_SHIFT'(0)}
                     + HASH_BITS'(s1_byte_reg);
        pos_after_lit = write_pos_reg + LIMIT_BITS'(!hit);
    end

    // The result queue must have room for two words before a byte is coded.
    assign s1_fire = s1_valid_reg && (fill_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign commit  = s1_fire && !drop;

    assign s_axis_tready = clr_done && (!s1_valid_reg || s1_fire);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Hash for the next byte's table read; a dropped byte leaves it unchanged.
    assign hash_next = commit ? hash_upd : hash_reg;

    // Table write port: the clearing pass, then misses.
    always_comb
    begin
        if (!clr_done)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg[HASH_BITS-1:0];
            tbl_wdata = '0;
        end
        else
        begin
            tbl_we    = commit && !hit;
            tbl_waddr = hash_reg;
            tbl_wdata = s1_byte_reg;
        end
    end

    assign fwd_next = commit && !hit && (hash_upd == hash_reg);

    pbc_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_guess_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (hash_next),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // State update. Configuration writes must arrive only while the block is idle; the block
    // does not enforce this, and a write simply takes priority.
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_cnt_next   = clr_done ? clr_cnt_reg : clr_cnt_reg + (HASH_BITS + 1)'(1);
        limit_next     = limit_reg;
        flag_bits_next = flag_bits_reg;
        flag_cnt_next  = flag_cnt_reg;
        flag_slot_next = flag_slot_reg;
        write_pos_next = write_pos_reg;
        ovf_next       = ovf_reg || (s1_fire && drop);
        s1_valid_next  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

        if (commit)
        begin
            if (completes)
            begin
                flag_bits_next = '0;
                flag_cnt_next  = '0;
                // The position after any literal becomes the next reserved flag slot.
                flag_slot_next = pos_after_lit[BUF_ADDR_BITS-1:0];
                write_pos_next = pos_after_lit + LIMIT_BITS'(1);
            end
            else
            begin
                flag_bits_next = flag_shift;
                flag_cnt_next  = flag_cnt_reg + FLAG_CNT_BITS'(1);
                write_pos_next = pos_after_lit;
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_BUFFER_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                REG_START_OFFSET:
                begin
                    flag_slot_next = cfg_data[BUF_ADDR_BITS-1:0];
                    write_pos_next = {1'b0, cfg_data[BUF_ADDR_BITS-1:0]} + LIMIT_BITS'(1);
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            limit_reg     <= ADDR_SPACE;
            hash_reg      <= '0;
            flag_bits_reg <= '0;
            flag_cnt_reg  <= '0;
            flag_slot_reg <= '0;
            write_pos_reg <= LIMIT_BITS'(1);
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            limit_reg     <= limit_next;
            hash_reg      <= hash_next;
            flag_bits_reg <= flag_bits_next;
            flag_cnt_reg  <= flag_cnt_next;
            flag_slot_reg <= flag_slot_next;
            write_pos_reg <= write_pos_next;
            ovf_reg       <= ovf_next;
            s1_valid_reg  <= s1_valid_next;
            if (accept)
            begin
                fwd_reg <= fwd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= s_axis_tdata[BYTE_BITS-1:0];
            fwd_data_reg <= s1_byte_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result words. A miss writes the literal; a completed flag byte follows it, or comes alone on a hit.
    // A dropped byte gives a single overflow word.
    // ------------------------------------------------------------------
    always_comb
    begin
        lit_res.write_enable = 1'b1;
        lit_res.write_addr   = write_pos_reg[BUF_ADDR_BITS-1:0];
        lit_res.write_data   = s1_byte_reg;
        lit_res.is_flag_byte = 1'b0;
        lit_res.overflow     = 1'b0;
        lit_res.last         = !completes;

        flag_res.write_enable = 1'b1;
        flag_res.write_addr   = flag_slot_reg;
        flag_res.write_data   = flag_shift;
        flag_res.is_flag_byte = 1'b1;
        flag_res.overflow     = 1'b0;
        flag_res.last         = 1'b1;

        ovf_res.write_enable = 1'b0;
        ovf_res.write_addr   = '0;
        ovf_res.write_data   = '0;
        ovf_res.is_flag_byte = 1'b0;
        ovf_res.overflow     = 1'b1;
        ovf_res.last         = 1'b1;

        push.valid0 = s1_fire && (drop || !hit || completes);
        push.valid1 = commit && !hit && completes;
        push.res0   = drop ? ovf_res : (!hit ? lit_res : flag_res);
        push.res1   = flag_res;
    end

    assign m_axis_tvalid = (fill_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    pbc_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .fill_count (fill_count)
    );

    assign m_axis_tdata = {6'd0, head.overflow, head.write_data, head.write_addr,
                           head.write_enable};
    assign m_axis_tuser = head.is_flag_byte;
    assign m_axis_tlast = head.last;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done |-> !s_axis_tready)
        else $error("byte accepted while the guess table is being cleared");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow state cleared after being set");

    a_flag_byte_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && completes && !cfg_we) |=> (flag_bits_reg == '0 && flag_cnt_reg == '0))
        else $error("flag byte state not restarted after a completed flag byte");

    a_drop_keeps_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && drop) |=> $stable(hash_reg) && $stable(flag_cnt_reg))
        else $error("dropped byte changed the coding state");
`endif

endmodule
